// ===== design/cpik_pkg.sv =====
// ----------------------------------------------------------------------------
// cpik_pkg
// Widths, register indexes and the shared target type of the cable plotter kinematics.
// ----------------------------------------------------------------------------
package cpik_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int MAG_W     = DATA_W + 2;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int RAD_W     = SQ_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DIFF_W    = ROOT_W;
    localparam int QUO_W     = DIFF_W + FRAC_BITS;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_TOOL_OFFSET_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_TOOL_OFFSET_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MOTOR_SPACING     = 3'd2;
    localparam logic [IDX_W-1:0] REG_REST_LENGTH_LEFT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_REST_LENGTH_RIGHT = 3'd4;
    localparam logic [IDX_W-1:0] REG_PULLEY_RADIUS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_JOINT_MODE        = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } target_t;

endpackage

// ===== design/cpik_sqrt.sv =====
// ----------------------------------------------------------------------------
// cpik_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module cpik_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [cpik_pkg::RAD_W-1:0]   rad,
    output logic [cpik_pkg::ROOT_W-1:0]  root
);
    import cpik_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [RAD_W-1:0]  rem_in;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W:0]    trial;
        logic              fits;

        if (k == 0) begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
        always_comb begin
            trial     = ((RAD_W+1)'(root_in) << (BIT + 1)) | ((RAD_W+1)'(1) << (2 * BIT));
            fits      = {1'b0, rem_in} >= trial;
            rem_next  = fits ? rem_in - trial[RAD_W-1:0] : rem_in;
            root_next = fits ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== design/cpik_div.sv =====
// ----------------------------------------------------------------------------
// cpik_div
// Pipelined restoring divider, one quotient bit per stage, sign carried along.
// ----------------------------------------------------------------------------
module cpik_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [cpik_pkg::QUO_W-1:0]  dividend,
    input  logic [cpik_pkg::CFG_W-1:0]  divisor,
    input  logic                        neg_in,
    output logic [cpik_pkg::QUO_W-1:0]  quotient,
    output logic                        neg_out
);
    import cpik_pkg::*;

    logic [QUO_W-1:0] num_reg [QUO_W];
    logic [CFG_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic             neg_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [QUO_W-1:0] num_in;
        logic [CFG_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic             neg_prev;
        logic [CFG_W:0]   shifted;
        logic [CFG_W:0]   reduced;
        logic             fits;

        if (k == 0) begin : g_first
            assign num_in   = dividend;
            assign rem_in   = '0;
            assign quo_in   = '0;
            assign neg_prev = neg_in;
        end else begin : g_rest
            assign num_in   = num_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign neg_prev = neg_reg[k-1];
        end

        always_comb begin
            shifted = {rem_in, num_in[BIT]};
            fits    = shifted >= {1'b0, divisor};
            reduced = fits ? shifted - {1'b0, divisor} : shifted;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= num_in;
                rem_reg[k] <= reduced[CFG_W-1:0];
                quo_reg[k] <= quo_in | (QUO_W'(fits) << BIT);
                neg_reg[k] <= neg_prev;
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];
    assign neg_out  = neg_reg[QUO_W-1];

endmodule

// ===== design/cable_plotter_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// cable_plotter_inverse_kinematics
// Two-cable plotter inverse kinematics: target (x, y, z) to joint angles.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one target per transfer, m_* one joint command per transfer.
//   cfg_* writes a register (cfg_index, cfg_data); cfg_ready is always high.
//   Write configuration only while no target is in flight.
//   Each item passes from its input transfer to m_tvalid through an input
//   register, three front stages (offset, squares, sums), 35 square-root
//   stages, one rest-length stage, 51 divider stages (one result bit per
//   stage) and the output register.
//   A new target is accepted every cycle while the skid register is empty; throughput is one item per cycle.
//   On a stall the result waits in the output register and the next one in
//   a skid register; the whole pipeline then holds until the skid empties.
//   Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module cable_plotter_inverse_kinematics (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*cpik_pkg::DATA_W-1:0]     s_tdata,   // target_x, target_y, target_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [3*cpik_pkg::DATA_W-1:0]     m_tdata,   // joint_left, joint_right, joint_z
    output logic [0:0]                        m_tuser,   // saturated
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpik_pkg::IDX_W-1:0]        cfg_index,
    input  logic [cpik_pkg::DATA_W-1:0]       cfg_data
);
    import cpik_pkg::*;

    localparam int SIDE_DEPTH = 4 + ROOT_W + 1 + QUO_W;
    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'd1 << (WORD_BITS - 1));

    logic [DATA_W-1:0] offset_x_reg;
    logic [DATA_W-1:0] offset_y_reg;
    logic [CFG_W-1:0]  spacing_reg;
    logic [CFG_W-1:0]  rest_l_reg;
    logic [CFG_W-1:0]  rest_r_reg;
    logic [CFG_W-1:0]  radius_reg;
    logic              joint_mode_reg;

    logic                  en;
    target_t               side_reg [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0] side_valid_reg;

    logic [MAG_W-1:0] mag_l_reg, mag_py_reg, mag_r_reg;
    logic [SQ_W-1:0]  sq_l_reg, sq_py_reg, sq_r_reg;
    logic [RAD_W-1:0] rad_l_reg, rad_r_reg;
    logic [DIFF_W-1:0] dmag_l_reg, dmag_r_reg;
    logic              dneg_l_reg, dneg_r_reg;

    logic [DATA_W:0]   px;
    logic [DATA_W:0]   py;
    logic [MAG_W-1:0]  px2;
    logic [MAG_W-1:0]  px_w;
    logic [ROOT_W-1:0] root_l, root_r;
    logic [DIFF_W:0]   diff_l, diff_r;
    logic [CFG_W-1:0]  divisor;
    logic [QUO_W-1:0]  quo_l, quo_r;
    logic              neg_l, neg_r;

    logic [DATA_W:0]       res_l, res_r;
    logic [3*DATA_W-1:0]   res_data;
    logic                  res_flag;
    logic                  tail_valid;

    logic                  out_valid_reg;
    logic [3*DATA_W-1:0]   out_data_reg;
    logic                  out_flag_reg;
    logic                  skid_valid_reg;
    logic [3*DATA_W-1:0]   skid_data_reg;
    logic                  skid_flag_reg;
    logic                  take;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            spacing_reg    <= CFG_W'(65536000);
            rest_l_reg     <= '0;
            rest_r_reg     <= '0;
            radius_reg     <= CFG_W'(65536);
            joint_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TOOL_OFFSET_X:     offset_x_reg   <= cfg_data;
                REG_TOOL_OFFSET_Y:     offset_y_reg   <= cfg_data;
                REG_MOTOR_SPACING:     spacing_reg    <= cfg_data[CFG_W-1:0];
                REG_REST_LENGTH_LEFT:  rest_l_reg     <= cfg_data[CFG_W-1:0];
                REG_REST_LENGTH_RIGHT: rest_r_reg     <= cfg_data[CFG_W-1:0];
                REG_PULLEY_RADIUS:     radius_reg     <= cfg_data[CFG_W-1:0];
                REG_JOINT_MODE:        joint_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline enable and item sideband (valid, raw target)
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_valid_reg <= '0;
        end else if (en) begin
            side_valid_reg <= {side_valid_reg[SIDE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= s_tdata;
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // offsets, magnitudes, squares and sums
    always_comb begin
        px   = {side_reg[0].x[DATA_W-1], side_reg[0].x} - {offset_x_reg[DATA_W-1], offset_x_reg};
        py   = {side_reg[0].y[DATA_W-1], side_reg[0].y} - {offset_y_reg[DATA_W-1], offset_y_reg};
        px_w = {px[DATA_W], px};
        px2  = MAG_W'(spacing_reg) - px_w;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_l_reg  <= px[DATA_W] ? MAG_W'(-px_w) : px_w;
            mag_py_reg <= py[DATA_W] ? MAG_W'(-{py[DATA_W], py}) : {py[DATA_W], py};
            mag_r_reg  <= px2[MAG_W-1] ? -px2 : px2;
            sq_l_reg   <= mag_l_reg * mag_l_reg;
            sq_py_reg  <= mag_py_reg * mag_py_reg;
            sq_r_reg   <= mag_r_reg * mag_r_reg;
            rad_l_reg  <= RAD_W'(sq_l_reg) + RAD_W'(sq_py_reg);
            rad_r_reg  <= RAD_W'(sq_r_reg) + RAD_W'(sq_py_reg);
        end
    end

    cpik_sqrt u_sqrt_l (.aclk(aclk), .en(en), .rad(rad_l_reg), .root(root_l));
    cpik_sqrt u_sqrt_r (.aclk(aclk), .en(en), .rad(rad_r_reg), .root(root_r));

    // length minus rest length
    always_comb begin
        diff_l = {1'b0, root_l} - (DIFF_W+1)'(rest_l_reg);
        diff_r = {1'b0, root_r} - (DIFF_W+1)'(rest_r_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dneg_l_reg <= diff_l[DIFF_W];
            dneg_r_reg <= diff_r[DIFF_W];
            dmag_l_reg <= diff_l[DIFF_W] ? DIFF_W'(-diff_l) : diff_l[DIFF_W-1:0];
            dmag_r_reg <= diff_r[DIFF_W] ? DIFF_W'(-diff_r) : diff_r[DIFF_W-1:0];
        end
    end

    assign divisor = (radius_reg == '0) ? CFG_W'(1) : radius_reg;

    cpik_div u_div_l (
        .aclk(aclk), .en(en),
        .dividend({dmag_l_reg, FRAC_BITS'(0)}), .divisor(divisor),
        .neg_in(dneg_l_reg), .quotient(quo_l), .neg_out(neg_l)
    );

    cpik_div u_div_r (
        .aclk(aclk), .en(en),
        .dividend({dmag_r_reg, FRAC_BITS'(0)}), .divisor(divisor),
        .neg_in(dneg_r_reg), .quotient(quo_r), .neg_out(neg_r)
    );

    // sign, clip to the signed word range; returns {clipped, value}
    function automatic logic [DATA_W:0] sat_angle(input logic [QUO_W-1:0] q, input logic neg);
        logic [QUO_W-1:0] nq;
        logic [QUO_W-1:0] nlim;
        nq   = QUO_W'(0) - q;
        nlim = QUO_W'(0) - LIM_NEG;
        if (!neg) begin
            sat_angle = (q > LIM_POS) ? {1'b1, LIM_POS[DATA_W-1:0]} : {1'b0, q[DATA_W-1:0]};
        end else begin
            sat_angle = (q > LIM_NEG) ? {1'b1, nlim[DATA_W-1:0]} : {1'b0, nq[DATA_W-1:0]};
        end
    endfunction

    always_comb begin
        res_l = sat_angle(quo_l, neg_l);
        res_r = sat_angle(quo_r, neg_r);
        if (joint_mode_reg) begin
            res_data = {side_reg[SIDE_DEPTH-1].z, side_reg[SIDE_DEPTH-1].y,
                        side_reg[SIDE_DEPTH-1].x};
            res_flag = 1'b0;
        end else begin
            res_data = {side_reg[SIDE_DEPTH-1].z, res_r[DATA_W-1:0], res_l[DATA_W-1:0]};
            res_flag = res_l[DATA_W] | res_r[DATA_W];
        end
    end

    assign tail_valid = side_valid_reg[SIDE_DEPTH-1];

    // output register and skid
    assign take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (tail_valid) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_flag_reg <= skid_flag_reg;
            end
        end else if (tail_valid) begin
            if (!out_valid_reg || take) begin
                out_data_reg <= res_data;
                out_flag_reg <= res_flag;
            end else begin
                skid_data_reg <= res_data;
                skid_flag_reg <= res_flag;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_flag_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(side_valid_reg))
        else $error("pipeline moved while the skid register was full");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid register did not drain after an output transfer");

    a_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == REG_JOINT_MODE |=> joint_mode_reg == $past(cfg_data[0]))
        else $error("joint mode register missed a write");

endmodule
